/* src/cda_pkg.sv */
package cda_pkg;

  localparam int MaxPersons = 10;
  localparam int HoldW      = 10;
  localparam int WayW       = 30;
  localparam int NumW       = 4;
  localparam int InDataW    = 16;
  localparam int OutDataW   = 32;

  localparam logic [WayW-1:0] WaysMod  = WayW'(1000000007);
  localparam logic [NumW-1:0] NumReset = NumW'(10);

  typedef enum logic [2:0] {
    StClear,
    StIdle,
    StWalk,
    StDrain,
    StLoad
  } cda_state_e;

  typedef struct packed {
    logic accept;
    logic walk;
    logic clear;
    logic load_out;
  } cda_cmd_t;

  typedef struct packed {
    logic walk_end;
    logic mask_zero;
    logic out_free;
    logic last_item;
  } cda_stat_t;

endpackage

/* src/cda_ctrl.sv */
module cda_ctrl
  import cda_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  cda_stat_t stat_i,
  output cda_cmd_t  cmd_o
);

  cda_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StClear: begin
        if (stat_i.mask_zero) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (in_valid_i) begin
          state_d = StWalk;
        end
      end
      StWalk: begin
        if (stat_i.walk_end) begin
          state_d = StDrain;
        end
      end
      StDrain: begin
        state_d = stat_i.last_item ? StLoad : StIdle;
      end
      StLoad: begin
        if (stat_i.out_free) begin
          state_d = StClear;
        end
      end
      default: begin
        state_d = StClear;
      end
    endcase
  end

  always_comb begin
    in_ready_o     = 1'b0;
    cmd_o          = '0;
    case (state_q)
      StClear: begin
        cmd_o.clear = 1'b1;
      end
      StIdle: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      StWalk: begin
        cmd_o.walk = 1'b1;
      end
      StDrain: begin
      end
      StLoad: begin
        cmd_o.load_out = stat_i.out_free;
      end
      default: begin
      end
    endcase
  end

endmodule

/* src/cda_dp.sv */
module cda_dp
  import cda_pkg::*;
#(
  parameter int MAX_PERSONS = MaxPersons
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic [NumW-1:0]     cfg_data_i,
  input  logic [HoldW-1:0]    holders_i,
  input  logic                last_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [WayW-1:0]     way_count_o,
  input  cda_cmd_t            cmd_i,
  output cda_stat_t           stat_o
);

  localparam int MaskW = MAX_PERSONS;
  localparam int Depth = 1 << MaskW;

  logic [WayW-1:0] mem [Depth];

  logic [NumW-1:0]  num_q;
  logic [MaskW-1:0] mask_q, mask_d;
  logic             self_q, self_d;
  logic [MaskW-1:0] rem_q, rem_d;
  logic [MaskW-1:0] hold_q;
  logic             last_q;

  logic             rd_vld_q;
  logic             rd_first_q;
  logic             rd_last_q;
  logic [MaskW-1:0] rd_mask_q;
  logic [WayW-1:0]  rdata_q;
  logic [WayW-1:0]  acc_q;
  logic [WayW-1:0]  res_q;
  logic             out_valid_q;
  logic [WayW-1:0]  out_data_q;

  logic [MaskW-1:0]       full_w;
  logic [HoldW+MaskW-1:0] hold_wide;
  logic [MaskW-1:0]       hold_ext;
  logic [MaskW-1:0]       low_bit;
  logic [MaskW-1:0]       rd_addr;
  logic                   grp_last;
  logic [WayW-1:0]        base;
  logic [WayW:0]          sum_raw;
  logic [WayW-1:0]        sum;
  logic                   wr_en;
  logic [MaskW-1:0]       wr_addr;
  logic [WayW-1:0]        wr_data;

  always_comb begin
    for (int i = 0; i < MaskW; i++) begin
      full_w[i] = (i < int'(num_q));
    end
  end

  assign hold_wide = {{MaskW{1'b0}}, holders_i};
  assign hold_ext  = hold_wide[MaskW-1:0];

  // walk one masked-off holder bit per read, lowest first
  assign low_bit  = rem_q & (~rem_q + MaskW'(1));
  assign rem_d    = self_q ? (hold_q & mask_q) : (rem_q & ~low_bit);
  assign grp_last = (rem_d == '0);
  assign rd_addr  = self_q ? mask_q : (mask_q ^ low_bit);

  always_comb begin
    mask_d = mask_q;
    self_d = self_q;
    if (cmd_i.accept || cmd_i.load_out) begin
      mask_d = '1;
      self_d = 1'b1;
    end else if (cmd_i.walk) begin
      self_d = grp_last;
      if (grp_last) begin
        mask_d = mask_q - MaskW'(1);
      end
    end else if (cmd_i.clear) begin
      mask_d = mask_q - MaskW'(1);
    end
  end

  assign base    = rd_first_q ? '0 : acc_q;
  assign sum_raw = {1'b0, base} + {1'b0, rdata_q};
  assign sum     = (sum_raw >= {1'b0, WaysMod}) ? WayW'(sum_raw - {1'b0, WaysMod})
                                               : sum_raw[WayW-1:0];

  assign wr_en   = cmd_i.clear || (rd_vld_q && rd_last_q);
  assign wr_addr = cmd_i.clear ? mask_q : rd_mask_q;
  assign wr_data = cmd_i.clear ? {{(WayW-1){1'b0}}, (mask_q == '0)} : sum;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd_i.walk) begin
      rdata_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q       <= NumReset;
      mask_q      <= '1;
      self_q      <= 1'b1;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        num_q <= cfg_data_i;
      end
      mask_q   <= mask_d;
      self_q   <= self_d;
      rd_vld_q <= cmd_i.walk;
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      hold_q <= hold_ext & full_w;
      last_q <= last_item_i;
    end
    if (cmd_i.walk) begin
      rem_q      <= rem_d;
      rd_first_q <= self_q;
      rd_last_q  <= grp_last;
      rd_mask_q  <= mask_q;
    end
    if (rd_vld_q) begin
      acc_q <= sum;
      if (rd_last_q && (rd_mask_q == full_w)) begin
        res_q <= sum;
      end
    end
    if (cmd_i.load_out) begin
      out_data_q <= res_q;
    end
  end

  assign stat_o.walk_end  = cmd_i.walk && grp_last && (mask_q == '0);
  assign stat_o.mask_zero = (mask_q == '0);
  assign stat_o.out_free  = !out_valid_q || out_ready_i;
  assign stat_o.last_item = last_q;

  assign out_valid_o = out_valid_q;
  assign way_count_o = out_data_q;

endmodule

/* src/count_distinct_assignments_mod_core.sv */
// Items are taken one at a time; an item walks all 2^MAX_PERSONS masks with one table read per mask
//   plus one per holder set in holders & mask, all through the one table read port.
// A last item passes the walk, the drain state and the load state, which loads the result register
//   once the output is free; the table is then cleared before the next item is taken.
// Reset: asynchronous, active low; num_persons returns to 10 and a clear of all 2^MAX_PERSONS
//   table entries runs before the first item is taken.
module count_distinct_assignments_mod_core
  import cda_pkg::*;
#(
  parameter int MAX_PERSONS = MaxPersons
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [NumW-1:0]     cfg_data_i,      // num_persons
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [InDataW-1:0]  s_axis_tdata_i,  // [9:0] holders, [15:10] zero
  input  logic                s_axis_tlast_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [OutDataW-1:0] m_axis_tdata_o   // [29:0] way_count, [31:30] zero
);

  cda_cmd_t        cmd;
  cda_stat_t       stat;
  logic [WayW-1:0] way_count;

  assign cfg_ready_o = 1'b1;

  cda_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  cda_dp #(
    .MAX_PERSONS (MAX_PERSONS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .holders_i   (s_axis_tdata_i[HoldW-1:0]),
    .last_item_i (s_axis_tlast_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .way_count_o (way_count),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

  assign m_axis_tdata_o = {{(OutDataW-WayW){1'b0}}, way_count};

endmodule

/* src/cda_chk.sv */
module cda_chk
  import cda_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid_i,
  input logic                s_axis_tready_o,
  input logic                m_axis_tvalid_o,
  input logic                m_axis_tready_i,
  input logic [OutDataW-1:0] m_axis_tdata_o
);

  // hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result dropped or changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("item taken while previous item still in work");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> !s_axis_tready_o)
    else $error("result loaded while input side open");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[WayW-1:0] < WaysMod)
    else $error("result not reduced");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[OutDataW-1:WayW] == '0)
    else $error("result padding not zero");

endmodule

bind count_distinct_assignments_mod_core cda_chk u_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
